// ----- rtl/core/slps_pkg.sv -----
`timescale 1ns / 1ps

package slps_pkg;

   localparam int VALUE_BITS       = 48;
   localparam int SEG_BITS         = 11;
   localparam int FUNC_BITS        = 2;
   localparam int STATUS_BITS      = 2;
   localparam int DEPTH_DEFAULT    = 1024;
   localparam int SUM_BITS_DEFAULT = 48;

   // func code 3 is unused and handled by the default arm
   typedef enum logic [FUNC_BITS-1:0] {
      FUNC_APPEND = 2'd0,
      FUNC_QUERY  = 2'd1,
      FUNC_CLEAR  = 2'd2
   } func_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_RANGE   = 2'd1,
      STATUS_REFUSED = 2'd2
   } status_type;

   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

endpackage

// ----- rtl/core/slps_if.sv -----
`timescale 1ns / 1ps

interface slps_req_if;
   logic                                valid;
   logic                                ready;
   slps_pkg::func_type                  func;
   logic [slps_pkg::VALUE_BITS-1:0]     value;

   modport source (output valid, output func, output value, input ready);
   modport sink   (input valid, input func, input value, output ready);
endinterface

interface slps_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [slps_pkg::SEG_BITS-1:0]       segment_number;
   logic [slps_pkg::VALUE_BITS-1:0]     offset;
   slps_pkg::status_type                status;

   modport source (output valid, output segment_number, output offset, output status,
                   input ready);
   modport sink   (input valid, input segment_number, input offset, input status,
                   output ready);
endinterface

// ----- rtl/core/slps_alu.sv -----
`timescale 1ns / 1ps

module slps_alu #(
   parameter int WIDTH = slps_pkg::VALUE_BITS
) (
   input  slps_pkg::alu_op_type op,
   input  logic [WIDTH-1:0]     a,
   input  logic [WIDTH-1:0]     b,
   output logic [WIDTH:0]       res
);
   import slps_pkg::*;

   // top bit is carry for add, borrow for subtract
   always_comb begin
      unique case (op)
         ALU_ADD: res = {1'b0, a} + {1'b0, b};
         ALU_SUB: res = {1'b0, a} - {1'b0, b};
      endcase
   end

endmodule

// ----- rtl/core/slps_table.sv -----
`timescale 1ns / 1ps

module slps_table #(
   parameter int DEPTH    = slps_pkg::DEPTH_DEFAULT,
   parameter int WIDTH    = slps_pkg::SUM_BITS_DEFAULT,
   parameter int IDX_BITS = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IDX_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]    wr_data,
   input  logic [IDX_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]    rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- rtl/core/segment_locate_by_prefix_sum_unit.sv -----
`timescale 1ns / 1ps

// Segment locator over a table of up to DEPTH running prefix sums (SUM_BITS each).
// One item at a time: the request side is ready only while the sequencer is idle.
// Append, clear, the unused code and an out-of-range query pass through S_EXEC to S_EMIT,
// which loads their result into the output register. An in-range query searches in S_EXEC
// and S_CMP, then forms the offset in S_SUB before S_EMIT; the binary search does one
// table read and one compare in the shared add/subtract unit per step.
// In the cycle after the result is loaded, the request side is ready again.
// The table has a single registered read port. A new request is taken while the
// previous result still waits in the output register.
module segment_locate_by_prefix_sum_unit #(
   parameter int DEPTH    = slps_pkg::DEPTH_DEFAULT,
   parameter int SUM_BITS = slps_pkg::SUM_BITS_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   slps_req_if.sink    req_ch,
   slps_rsp_if.source  rsp_ch
);
   import slps_pkg::*;

   localparam int IDX_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam int OP_BITS  = (SUM_BITS > VALUE_BITS) ? SUM_BITS : VALUE_BITS;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_CMP,
      S_SUB,
      S_EMIT
   } state_type;

   state_type              state_ff;
   func_type               func_ff;
   logic [VALUE_BITS-1:0]  value_ff;
   logic [CNT_BITS-1:0]    count_ff;
   logic [SUM_BITS-1:0]    total_ff;
   logic [IDX_BITS-1:0]    lo_ff;
   logic [IDX_BITS-1:0]    hi_ff;
   logic [IDX_BITS-1:0]    mid_ff;
   logic                   zero_prev_ff;
   logic [SEG_BITS-1:0]    res_seg_ff;
   logic [VALUE_BITS-1:0]  res_off_ff;
   status_type             res_status_ff;
   logic                   rsp_valid_ff;
   logic [SEG_BITS-1:0]    rsp_seg_ff;
   logic [VALUE_BITS-1:0]  rsp_off_ff;
   status_type             rsp_status_ff;

   alu_op_type             alu_op;
   logic [OP_BITS-1:0]     alu_a;
   logic [OP_BITS-1:0]     alu_b;
   logic [OP_BITS:0]       alu_res;
   logic                   alu_pos;

   logic [IDX_BITS-1:0]    lo_in;
   logic [IDX_BITS-1:0]    hi_in;
   logic [IDX_BITS:0]      mid_sum;
   logic [IDX_BITS-1:0]    mid_in;
   logic                   search_done;
   logic [IDX_BITS-1:0]    rd_addr;
   logic [SUM_BITS-1:0]    rd_data;

   logic                   full;
   logic                   overflow;
   logic                   out_of_range;
   logic                   wr_en;

   slps_alu #(.WIDTH(OP_BITS)) u_alu (
      .op  (alu_op),
      .a   (alu_a),
      .b   (alu_b),
      .res (alu_res)
   );

   slps_table #(.DEPTH(DEPTH), .WIDTH(SUM_BITS), .IDX_BITS(IDX_BITS)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_BITS-1:0]),
      .wr_data (alu_res[SUM_BITS-1:0]),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign alu_a = OP_BITS'(value_ff);

   always_comb begin
      alu_op = ALU_SUB;
      alu_b  = OP_BITS'(rd_data);
      unique case (state_ff)
         S_EXEC: begin
            alu_op = (func_ff == FUNC_APPEND) ? ALU_ADD : ALU_SUB;
            alu_b  = OP_BITS'(total_ff);
         end
         S_SUB: begin
            alu_b = zero_prev_ff ? '0 : OP_BITS'(rd_data);
         end
         S_IDLE, S_CMP, S_EMIT: begin
            alu_b = OP_BITS'(rd_data);
         end
      endcase
   end

   // value strictly above the other operand
   assign alu_pos = !alu_res[OP_BITS] && (alu_res != '0);

   // lower-bound search window; entry to search starts over all stored entries
   always_comb begin
      if (state_ff == S_CMP) begin
         if (alu_pos) begin
            lo_in = IDX_BITS'(mid_ff + 1'b1);
            hi_in = hi_ff;
         end else begin
            lo_in = lo_ff;
            hi_in = mid_ff;
         end
      end else begin
         lo_in = '0;
         hi_in = IDX_BITS'(count_ff - 1'b1);
      end
   end

   assign mid_sum     = {1'b0, lo_in} + {1'b0, hi_in};
   assign mid_in      = mid_sum[IDX_BITS:1];
   assign search_done = (lo_in == hi_in);
   // once the window closes, fetch the sum that precedes the found segment
   assign rd_addr     = search_done ? IDX_BITS'(lo_in - 1'b1) : mid_in;

   assign full         = (count_ff == CNT_BITS'(DEPTH));
   assign overflow     = (alu_res[OP_BITS:SUM_BITS] != '0);
   assign out_of_range = (count_ff == '0) || (value_ff == '0) || alu_pos;
   assign wr_en        = (state_ff == S_EXEC) && (func_ff == FUNC_APPEND) && !full && !overflow;

   assign req_ch.ready          = (state_ff == S_IDLE);
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.segment_number = rsp_seg_ff;
   assign rsp_ch.offset         = rsp_off_ff;
   assign rsp_ch.status         = rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // S_EMIT reloads the output register itself
         if (rsp_valid_ff && rsp_ch.ready && (state_ff != S_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_ch.valid) begin
                  func_ff  <= req_ch.func;
                  value_ff <= req_ch.value;
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               unique case (func_ff)
                  FUNC_APPEND: begin
                     res_off_ff <= '0;
                     state_ff   <= S_EMIT;
                     if (full || overflow) begin
                        res_seg_ff    <= SEG_BITS'(count_ff);
                        res_status_ff <= STATUS_REFUSED;
                     end else begin
                        count_ff      <= count_ff + 1'b1;
                        total_ff      <= alu_res[SUM_BITS-1:0];
                        res_seg_ff    <= SEG_BITS'(count_ff + 1'b1);
                        res_status_ff <= STATUS_OK;
                     end
                  end
                  FUNC_QUERY: begin
                     if (out_of_range) begin
                        res_seg_ff    <= '0;
                        res_off_ff    <= '0;
                        res_status_ff <= STATUS_RANGE;
                        state_ff      <= S_EMIT;
                     end else begin
                        lo_ff  <= lo_in;
                        hi_ff  <= hi_in;
                        mid_ff <= mid_in;
                        if (search_done) begin
                           zero_prev_ff <= (lo_in == '0);
                           state_ff     <= S_SUB;
                        end else begin
                           state_ff <= S_CMP;
                        end
                     end
                  end
                  FUNC_CLEAR: begin
                     count_ff      <= '0;
                     total_ff      <= '0;
                     res_seg_ff    <= '0;
                     res_off_ff    <= '0;
                     res_status_ff <= STATUS_OK;
                     state_ff      <= S_EMIT;
                  end
                  default: begin
                     res_seg_ff    <= SEG_BITS'(count_ff);
                     res_off_ff    <= '0;
                     res_status_ff <= STATUS_OK;
                     state_ff      <= S_EMIT;
                  end
               endcase
            end
            S_CMP: begin
               lo_ff  <= lo_in;
               hi_ff  <= hi_in;
               mid_ff <= mid_in;
               if (search_done) begin
                  zero_prev_ff <= (lo_in == '0);
                  state_ff     <= S_SUB;
               end
            end
            S_SUB: begin
               res_seg_ff    <= SEG_BITS'({1'b0, lo_ff} + 1'b1);
               res_off_ff    <= alu_res[VALUE_BITS-1:0];
               res_status_ff <= STATUS_OK;
               state_ff      <= S_EMIT;
            end
            S_EMIT: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_seg_ff    <= res_seg_ff;
                  rsp_off_ff    <= res_off_ff;
                  rsp_status_ff <= res_status_ff;
                  state_ff      <= S_IDLE;
               end
            end
         endcase
      end
   end

endmodule
